// File: sv/opwt_pkg.sv
package opwt_pkg;

	localparam int FRAME_BYTES = 2;
	localparam int FRAME_BITS  = FRAME_BYTES * 8;
	localparam int BIT_W       = $clog2(FRAME_BITS);
	localparam int SHORT_W     = 10;
	localparam int TIME_W      = 21;
	localparam int CNT8_W      = 8;

	localparam int MID_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF = 2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_REPEATS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROUPS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_GAP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_R2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_R3  = 3'd5;

	localparam logic [7:0]         RST_REPEATS   = 8'd4;
	localparam logic [7:0]         RST_FRAME_GAP = 8'd5;
	localparam logic [7:0]         RST_GROUPS    = 8'd2;
	localparam logic [7:0]         RST_GROUP_GAP = 8'd50;
	localparam logic [SHORT_W-1:0] RST_SHORT_R2  = 10'd600;
	localparam logic [SHORT_W-1:0] RST_SHORT_R3  = 10'd185;

	localparam logic [3:0] FRAME_HEAD = 4'b0110;

	localparam logic [1:0] PRODUCT_REV2 = 2'd0;
	localparam logic [1:0] PRODUCT_REV3 = 2'd1;
	localparam logic [1:0] CHANNEL_BAD  = 2'd3;
	localparam logic [1:0] OUTLET_BAD   = 2'd0;
	localparam logic       REQ_TICK     = 1'b0;
	localparam logic       REQ_START    = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [1:0] product;
		logic [1:0] channel;
		logic [1:0] outlet;
		logic       switch_on;
	} in_item_t;

	typedef struct packed {
		logic pin_level;
		logic busy_res;
		logic rejected;
	} out_item_t;

	typedef struct packed {
		logic [7:0]         repeats_per_group;
		logic [7:0]         frame_gap_scale;
		logic [7:0]         group_count;
		logic [7:0]         group_gap_scale;
		logic [SHORT_W-1:0] short_time_rev2;
		logic [SHORT_W-1:0] short_time_rev3;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic                  is_cmd;
		logic                  cmd_ok;
		logic [FRAME_BITS-1:0] frame;
		logic [SHORT_W-1:0]    short_time;
	} mid_t;

	function automatic logic [7:0] body_code(input logic [1:0] outlet, input logic on);
		logic [7:0] code;
		code = 8'h00;
		case (outlet)
			2'd1: code = on ? 8'h88 : 8'h84;
			2'd2: code = on ? 8'h82 : 8'h81;
			2'd3: code = on ? 8'h90 : 8'hA0;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

// File: sv/ook_pulse_width_outlet_transmitter.sv
// OOK pulse-width outlet transmitter, one microsecond per tick item.
// Input channel: push/full queue. Each item is a tick (req_type 0) or a start
// command (req_type 1) with product, channel, outlet and switch_on.
// Result channel: empty/pop queue. Every input item yields exactly one
// result: the pin level during that tick, whether a transmission is still in
// progress afterwards, and a reject flag for bad or busy-time commands.
// Configuration: wr_en/wr_index/wr_data, no read-back;
// write only while the block is idle.
// A result passes the front stage register, the middle queue and then the
// sequencer writing the result queue before it is on the result ports.
// Throughput: one item per cycle while the result queue is being popped; the
// sequencer takes one step per item; front stage, middle queue and result queue
// each take one transfer per cycle.
// When the receiver stops popping, the result queue fills, then the middle
// queue and front stage, and full rises; nothing is dropped.
// Reset clears the queues and the sequencer (idle, line low) and loads the
// register defaults: 4 frames per group, frame gap 5, 2 groups, group gap 50,
// short time 600 us (revision two) and 185 us (revision three).
module ook_pulse_width_outlet_transmitter
	import opwt_pkg::*;
#(
	parameter int MID_DEPTH = MID_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  in_item_t              item,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output out_item_t             result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	cfg_t      cfg_q;
	logic      mid_push, mid_full, mid_empty, mid_pop;
	mid_t      mid_wdata, mid_rdata;
	logic      res_push, res_full;
	out_item_t res_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeats_per_group <= RST_REPEATS;
			cfg_q.frame_gap_scale   <= RST_FRAME_GAP;
			cfg_q.group_count       <= RST_GROUPS;
			cfg_q.group_gap_scale   <= RST_GROUP_GAP;
			cfg_q.short_time_rev2   <= RST_SHORT_R2;
			cfg_q.short_time_rev3   <= RST_SHORT_R3;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_REPEATS:   cfg_q.repeats_per_group <= wr_data[7:0];
				REG_FRAME_GAP: cfg_q.frame_gap_scale   <= wr_data[7:0];
				REG_GROUPS:    cfg_q.group_count       <= wr_data[7:0];
				REG_GROUP_GAP: cfg_q.group_gap_scale   <= wr_data[7:0];
				REG_SHORT_R2:  cfg_q.short_time_rev2   <= wr_data[SHORT_W-1:0];
				REG_SHORT_R3:  cfg_q.short_time_rev3   <= wr_data[SHORT_W-1:0];
				default: ;
			endcase
		end
	end

	opwt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cfg      (cfg_q),
		.mid_push (mid_push),
		.mid_item (mid_wdata),
		.mid_full (mid_full)
	);

	opwt_fifo #(
		.WIDTH ($bits(mid_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	opwt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_item  (mid_rdata),
		.mid_pop   (mid_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_item  (res_wdata)
	);

	opwt_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

// File: sv/opwt_fifo.sv
module opwt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// File: sv/opwt_front.sv
module opwt_front
	import opwt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	input  cfg_t     cfg,
	output logic     mid_push,
	output mid_t     mid_item,
	input  logic     mid_full
);

	logic     valid_s1;
	mid_t     entry_s1;
	mid_t     cls;
	logic     accept;

	assign full     = valid_s1 && mid_full;
	assign accept   = push && !full;
	assign mid_push = valid_s1;
	assign mid_item = entry_s1;

	// static checks only; the busy check belongs to the back end
	always_comb begin
		cls.is_cmd = (item.req_type == REQ_START);
		cls.cmd_ok = (item.product == PRODUCT_REV2 || item.product == PRODUCT_REV3)
			&& (item.channel != CHANNEL_BAD) && (item.outlet != OUTLET_BAD);
		cls.frame  = {FRAME_HEAD, body_code(item.outlet, item.switch_on), 2'b00, item.channel};
		cls.short_time = (item.product == PRODUCT_REV2) ? cfg.short_time_rev2
			: cfg.short_time_rev3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!mid_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= cls;
		end
	end

endmodule

// File: sv/opwt_back.sv
module opwt_back
	import opwt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      mid_empty,
	input  mid_t      mid_item,
	output logic      mid_pop,
	input  logic      res_full,
	output logic      res_push,
	output out_item_t res_item
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;
	localparam logic [1:0] PH_GAP  = 2'd3;

	localparam logic [BIT_W-1:0] LAST = BIT_W'(FRAME_BITS - 1);
	localparam int GAP_W = SHORT_W + 8 + 2;

	logic [FRAME_BITS-1:0] frame_q, frame_n;
	logic [BIT_W-1:0]      bit_q, bit_n;
	logic [1:0]            phase_q, phase_n;
	logic [TIME_W-1:0]     time_q, time_n, tdec;
	logic [SHORT_W-1:0]    short_q, short_n;
	logic [CNT8_W-1:0]     frames_q, frames_n, fdec;
	logic [CNT8_W-1:0]     groups_q, groups_n, gdec;
	logic [GAP_W-1:0]      fgap_q, ggap_q, gap_sel;
	logic [SHORT_W+1:0]    s3, m3;
	logic                  step, rej;

	assign step     = !mid_empty && !res_full;
	assign mid_pop  = step;
	assign res_push = step;

	assign s3   = {2'b00, short_q} + {1'b0, short_q, 1'b0};
	assign m3   = {2'b00, mid_item.short_time} + {1'b0, mid_item.short_time, 1'b0};
	assign tdec = time_q - 1'b1;
	assign fdec = frames_q - 1'b1;
	assign gdec = groups_q - 1'b1;

	always_comb begin
		frame_n  = frame_q;
		bit_n    = bit_q;
		phase_n  = phase_q;
		time_n   = time_q;
		short_n  = short_q;
		frames_n = frames_q;
		groups_n = groups_q;
		gap_sel  = fgap_q;
		rej      = 1'b0;
		if (step) begin
			if (mid_item.is_cmd) begin
				if (phase_q != PH_IDLE || !mid_item.cmd_ok) begin
					rej = 1'b1;
				end else begin
					short_n  = mid_item.short_time;
					frame_n  = mid_item.frame;
					groups_n = cfg.group_count;
					frames_n = cfg.repeats_per_group;
					bit_n    = '0;
					if (mid_item.short_time == '0 || cfg.group_count == '0
						|| cfg.repeats_per_group == '0) begin
						phase_n  = PH_IDLE;
						time_n   = '0;
						frames_n = '0;
						groups_n = '0;
					end else begin
						phase_n = PH_HIGH;
						time_n  = mid_item.frame[LAST] ? TIME_W'(m3) : TIME_W'(mid_item.short_time);
					end
				end
			end else if (phase_q != PH_IDLE) begin
				time_n = tdec;
				if (tdec == '0) begin
					unique case (phase_q)
						PH_HIGH: begin
							phase_n = PH_LOW;
							time_n  = frame_q[LAST - bit_q] ? TIME_W'(short_q) : TIME_W'(s3);
						end
						PH_LOW: begin
							if (bit_q != LAST) begin
								bit_n   = bit_q + 1'b1;
								phase_n = PH_HIGH;
								time_n  = frame_q[LAST - bit_n] ? TIME_W'(s3) : TIME_W'(short_q);
							end else begin
								frames_n = fdec;
								if (fdec == '0) begin
									groups_n = gdec;
									frames_n = cfg.repeats_per_group;
									gap_sel  = ggap_q;
								end
								if (fdec == '0 && (gdec == '0 || cfg.repeats_per_group == '0)) begin
									phase_n  = PH_IDLE;
									time_n   = '0;
									bit_n    = '0;
									frames_n = '0;
									groups_n = '0;
								end else if (gap_sel == '0) begin
									// zero gap: next frame starts at once
									bit_n   = '0;
									phase_n = PH_HIGH;
									time_n  = frame_q[LAST] ? TIME_W'(s3) : TIME_W'(short_q);
								end else begin
									phase_n = PH_GAP;
									time_n  = TIME_W'(gap_sel);
								end
							end
						end
						PH_GAP: begin
							bit_n   = '0;
							phase_n = PH_HIGH;
							time_n  = frame_q[LAST] ? TIME_W'(s3) : TIME_W'(short_q);
						end
						default: begin
							phase_n  = PH_IDLE;
							time_n   = '0;
							bit_n    = '0;
							frames_n = '0;
							groups_n = '0;
						end
					endcase
				end
			end
		end
	end

	always_comb begin
		res_item.pin_level = (phase_q == PH_HIGH);
		res_item.busy_res  = (phase_n != PH_IDLE);
		res_item.rejected  = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q  <= '0;
			bit_q    <= '0;
			phase_q  <= PH_IDLE;
			time_q   <= '0;
			short_q  <= '0;
			frames_q <= '0;
			groups_q <= '0;
		end else begin
			frame_q  <= frame_n;
			bit_q    <= bit_n;
			phase_q  <= phase_n;
			time_q   <= time_n;
			short_q  <= short_n;
			frames_q <= frames_n;
			groups_q <= groups_n;
		end
	end

	// gap lengths, 4 * short * scale; short is fixed long before the first gap
	always_ff @(posedge clk) begin
		fgap_q <= {(GAP_W-2)'(short_q) * (GAP_W-2)'(cfg.frame_gap_scale), 2'b00};
		ggap_q <= {(GAP_W-2)'(short_q) * (GAP_W-2)'(cfg.group_gap_scale), 2'b00};
	end

	a_busy_time: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> time_q != '0)
		else $error("active phase with zero time left");

	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> short_q != '0)
		else $error("active phase with zero short time");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> (frames_q == '0 && groups_q == '0 && bit_q == '0))
		else $error("idle with leftover counters");

	a_rej_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_item.rejected) |-> mid_item.is_cmd)
		else $error("tick flagged as rejected");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step && mid_item.is_cmd && phase_q != PH_IDLE) |=> phase_q != PH_IDLE)
		else $error("command while busy disturbed transmission");

endmodule
